// ----- rtl/cls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

   localparam int CMD_LEN_DEFAULT = 4096;
   localparam int QUEUE_DEPTH     = 4;
   localparam int RSP_DEPTH       = 4;

   localparam logic [13:0] BUF_CAP_RESET  = 14'd8192;
   localparam logic [12:0] ARGV_CAP_RESET = 13'd4097;
   localparam logic [13:0] DEST_MAX       = 14'h3fff;
   localparam logic [12:0] ARGC_MAX       = 13'h1fff;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_BS    = 8'h5c;

   localparam logic [1:0] CSR_COUNT_ONLY = 2'd0;
   localparam logic [1:0] CSR_BUF_CAP    = 2'd1;
   localparam logic [1:0] CSR_ARGV_CAP   = 2'd2;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ARGV_SMALL = 3'd1,
      ST_BUF_SMALL  = 3'd2,
      ST_ESCAPE     = 3'd3,
      ST_QUOTE      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CK_NUL   = 3'd0,
      CK_WS    = 3'd1,
      CK_DQ    = 3'd2,
      CK_BS    = 3'd3,
      CK_SQ    = 3'd4,
      CK_OTHER = 3'd5
   } chr_kind_type;

   typedef enum logic [3:0] {
      MODE_BETWEEN = 4'b0001,
      MODE_ARG     = 4'b0010,
      MODE_STRONG  = 4'b0100,
      MODE_SKIP    = 4'b1000
   } mode_type;

   typedef struct packed {
      logic        count_only;
      logic [13:0] buf_cap;
      logic [12:0] argv_cap;
   } cfg_type;

   typedef struct packed {
      chr_kind_type kind;
      logic [7:0]   ch;
   } front_item_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   out_byte;
      logic [12:0]  buf_offset;
      logic [11:0]  arg_index;
      status_type   status;
      logic [11:0]  err_pos;
      logic [13:0]  buf_used;
      logic [12:0]  argv_used;
      logic         last;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/command_line_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shell-style command line splitter.
// req_ch takes one character per beat (req_push while req_full is low); a zero
// character ends the command. Each beat on the rsp_ side (rsp_pop while
// rsp_empty is low) carries one result: an argument byte, an argument end or
// the command finish with its status, buffer use and argv use.
// csr_ writes set count_only, buf_capacity and argv_capacity (index 0, 1, 2);
// csr_ready is always high. Write them only between commands.
// A front stage classifies characters into a four-entry queue; the back
// tokenizer takes one character per cycle, unless the result queue is full
// or a finish result is owed, and writes results into a four-entry result
// queue; a character passes the front register and both queues on its way
// out. A terminator that closes an open argument gives its end, then the
// finish, and no character is taken while that finish is owed.
// Reset empties both queues, returns the tokenizer to its start state and
// restores the register defaults. When the receiver stalls, results collect
// in the result queue, then in the character queue and the front stage, and
// req_full rises once all of them are full; nothing is dropped.
module command_line_splitter
   import cls_pkg::*;
#(
   parameter int MAX_CMD_LEN = CMD_LEN_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_ch,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [12:0]      rsp_buf_offset,
   output logic [11:0]      rsp_arg_index,
   output logic [2:0]       rsp_status,
   output logic [11:0]      rsp_err_pos,
   output logic [13:0]      rsp_buf_used,
   output logic [12:0]      rsp_argv_used,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [13:0] csr_data
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_push, q_full, q_empty, q_pop;
   front_item_type f_item, b_item;
   logic           out_push, out_full;
   result_type     out_res, rsp_res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COUNT_ONLY: cfg_in.count_only = csr_data[0];
            CSR_BUF_CAP:    cfg_in.buf_cap    = csr_data;
            CSR_ARGV_CAP:   cfg_in.argv_cap   = csr_data[12:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{count_only: 1'b0, buf_cap: BUF_CAP_RESET, argv_cap: ARGV_CAP_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cls_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_ch   (req_ch),
      .req_full (req_full),
      .q_push   (q_push),
      .q_item   (f_item),
      .q_full   (q_full)
   );

   cls_fifo #(
      .WIDTH ($bits(front_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_char_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (f_item),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (b_item),
      .empty (q_empty)
   );

   cls_back #(
      .MAX_CMD_LEN (MAX_CMD_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_item   (b_item),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_res  (out_res)
   );

   cls_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_res),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_res),
      .empty (rsp_empty)
   );

   assign rsp_kind       = rsp_res.kind;
   assign rsp_out_byte   = rsp_res.out_byte;
   assign rsp_buf_offset = rsp_res.buf_offset;
   assign rsp_arg_index  = rsp_res.arg_index;
   assign rsp_status     = rsp_res.status;
   assign rsp_err_pos    = rsp_res.err_pos;
   assign rsp_buf_used   = rsp_res.buf_used;
   assign rsp_argv_used  = rsp_res.argv_used;
   assign rsp_last       = rsp_res.last;

endmodule

`default_nettype wire

// ----- rtl/cls_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cls_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/cls_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cls_front
   import cls_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_push,
   input  wire logic [7:0] req_ch,
   output logic          req_full,
   output logic          q_push,
   output front_item_type q_item,
   input  wire logic     q_full
);

   logic           valid_ff, valid_in;
   front_item_type item_ff, item_in;
   logic           accept;
   chr_kind_type   kind;

   always_comb begin
      case (req_ch)
         CH_NUL:                  kind = CK_NUL;
         CH_SPACE, CH_TAB, CH_LF: kind = CK_WS;
         CH_DQ:                   kind = CK_DQ;
         CH_BS:                   kind = CK_BS;
         CH_SQ:                   kind = CK_SQ;
         default:                 kind = CK_OTHER;
      endcase
   end

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in  = '{kind: kind, ch: req_ch};
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ----- rtl/cls_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cls_back
   import cls_pkg::*;
#(
   parameter int MAX_CMD_LEN = CMD_LEN_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire front_item_type q_item,
   input  wire logic     q_empty,
   output logic          q_pop,
   input  wire logic     out_full,
   output logic          out_push,
   output result_type    out_res
);

   localparam int POS_W = $clog2(MAX_CMD_LEN);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CMD_LEN - 1);

   mode_type         mode_ff, mode_in;
   logic             weak_ff, weak_in;
   logic             esc_ff, esc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] qpos_ff, qpos_in;
   logic [13:0]      dest_ff, dest_in;
   logic [12:0]      argc_ff, argc_in;
   // finish result owed after an argument ended by the terminator
   logic             pend_ff, pend_in;
   logic [13:0]      bu_ff, bu_in;
   logic [12:0]      au_ff, au_in;

   function automatic result_type done_res(status_type st, logic [11:0] ep,
                                           logic [13:0] bu, logic [12:0] au);
      result_type r;
      r = '0;
      r.kind      = KIND_DONE;
      r.status    = st;
      r.err_pos   = ep;
      r.buf_used  = bu;
      r.argv_used = au;
      r.last      = 1'b1;
      return r;
   endfunction

   assign q_pop = !q_empty && !pend_ff && !out_full;

   always_comb begin
      logic             full, is_nul, in_arg, adv, clear;
      logic             fail, want_dest, fin_after;
      status_type       fcode;
      logic [POS_W-1:0] fpos;
      logic [31:0]      fpos_w;
      rsp_kind_type     dkind;
      logic [7:0]       dbyte;
      logic [12:0]      argc_cur;
      logic [13:0]      dest_next;

      mode_in   = mode_ff;
      weak_in   = weak_ff;
      esc_in    = esc_ff;
      pos_in    = pos_ff;
      qpos_in   = qpos_ff;
      dest_in   = dest_ff;
      argc_in   = argc_ff;
      pend_in   = pend_ff;
      bu_in     = bu_ff;
      au_in     = au_ff;
      out_push  = 1'b0;
      out_res   = '0;
      full      = !cfg.count_only && (dest_ff >= cfg.buf_cap);
      is_nul    = (q_item.kind == CK_NUL);
      in_arg    = 1'b0;
      adv       = 1'b0;
      clear     = 1'b0;
      fail      = 1'b0;
      want_dest = 1'b0;
      fin_after = 1'b0;
      fcode     = ST_OK;
      fpos      = '0;
      fpos_w    = '0;
      dkind     = KIND_BYTE;
      dbyte     = q_item.ch;
      argc_cur  = argc_ff;
      dest_next = (dest_ff < DEST_MAX) ? dest_ff + 14'd1 : dest_ff;

      if (pend_ff) begin
         if (!out_full) begin
            out_push = 1'b1;
            out_res  = done_res(ST_OK, 12'd0, bu_ff, au_ff);
            pend_in  = 1'b0;
         end
      end else if (q_pop) begin
         if (mode_ff == MODE_SKIP) begin
            if (is_nul) clear = 1'b1;
            else adv = 1'b1;
         end else if (pos_ff == '0 && mode_ff == MODE_BETWEEN && !cfg.count_only &&
                      cfg.argv_cap == '0) begin
            fail  = 1'b1;
            fcode = ST_ARGV_SMALL;
         end else begin
            case (mode_ff)
               MODE_BETWEEN: begin
                  if (is_nul) begin
                     out_push = 1'b1;
                     out_res  = done_res(ST_OK, 12'd0, dest_ff, argc_ff + 13'd1);
                     clear    = 1'b1;
                  end else if (q_item.kind == CK_WS) begin
                     adv = 1'b1;
                  end else if (!cfg.count_only &&
                               ({1'b0, cfg.argv_cap} < {1'b0, argc_ff} + 14'd2)) begin
                     fail  = 1'b1;
                     fcode = ST_ARGV_SMALL;
                  end else begin
                     if (argc_ff < ARGC_MAX) argc_cur = argc_ff + 13'd1;
                     argc_in = argc_cur;
                     mode_in = MODE_ARG;
                     in_arg  = 1'b1;
                  end
               end
               MODE_STRONG: begin
                  if (full) begin
                     fail  = 1'b1;
                     fcode = ST_BUF_SMALL;
                  end else if (is_nul) begin
                     fail  = 1'b1;
                     fcode = ST_QUOTE;
                     fpos  = qpos_ff;
                  end else begin
                     if (q_item.kind == CK_SQ) mode_in = MODE_ARG;
                     else want_dest = 1'b1;
                     adv = 1'b1;
                  end
               end
               default: in_arg = 1'b1;
            endcase

            if (in_arg) begin
               adv = 1'b1;
               if (esc_ff) begin
                  if (is_nul) begin
                     fail  = 1'b1;
                     fcode = ST_ESCAPE;
                     fpos  = pos_ff - 1'b1;
                  end else begin
                     esc_in    = 1'b0;
                     want_dest = 1'b1;
                  end
               end else begin
                  case (q_item.kind)
                     CK_DQ: begin
                        weak_in = !weak_ff;
                        qpos_in = pos_ff;
                     end
                     CK_BS: esc_in = 1'b1;
                     CK_WS: begin
                        if (!weak_ff) begin
                           want_dest = 1'b1;
                           dkind     = KIND_END;
                           mode_in   = MODE_BETWEEN;
                        end else begin
                           want_dest = 1'b1;
                        end
                     end
                     CK_SQ: begin
                        if (!weak_ff) begin
                           qpos_in = pos_ff;
                           if (full) begin
                              fail  = 1'b1;
                              fcode = ST_BUF_SMALL;
                           end else begin
                              mode_in = MODE_STRONG;
                           end
                        end else begin
                           want_dest = 1'b1;
                        end
                     end
                     CK_NUL: begin
                        if (weak_ff) begin
                           fail  = 1'b1;
                           fcode = ST_QUOTE;
                           fpos  = qpos_ff;
                        end else if (full) begin
                           fail  = 1'b1;
                           fcode = ST_BUF_SMALL;
                        end else begin
                           want_dest = 1'b1;
                           dkind     = KIND_END;
                           fin_after = 1'b1;
                        end
                     end
                     default: want_dest = 1'b1;
                  endcase
               end
            end

            if (want_dest) begin
               if (dkind != KIND_BYTE) dbyte = 8'd0;
               if (full) begin
                  fail  = 1'b1;
                  fcode = ST_BUF_SMALL;
               end else begin
                  out_push = 1'b1;
                  out_res  = '0;
                  out_res.kind       = dkind;
                  out_res.out_byte   = dbyte;
                  out_res.buf_offset = dest_ff[12:0];
                  out_res.arg_index  = 12'(argc_cur - 13'd1);
                  dest_in = dest_next;
                  if (fin_after) begin
                     pend_in = 1'b1;
                     bu_in   = dest_next;
                     au_in   = argc_cur + 13'd1;
                     clear   = 1'b1;
                  end
               end
            end
         end

         if (fail) begin
            fpos_w   = 32'(fpos);
            out_push = 1'b1;
            out_res  = done_res(fcode, fpos_w[11:0], 14'd0, 13'd0);
            if (is_nul) clear = 1'b1;
            else mode_in = MODE_SKIP;
         end

         if (adv) begin
            pos_in = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : POS_MAX;
         end
         if (clear) begin
            mode_in = MODE_BETWEEN;
            weak_in = 1'b0;
            esc_in  = 1'b0;
            pos_in  = '0;
            qpos_in = '0;
            dest_in = '0;
            argc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         weak_ff <= 1'b0;
         esc_ff  <= 1'b0;
         pos_ff  <= '0;
         qpos_ff <= '0;
         dest_ff <= '0;
         argc_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         weak_ff <= weak_in;
         esc_ff  <= esc_in;
         pos_ff  <= pos_in;
         qpos_ff <= qpos_in;
         dest_ff <= dest_in;
         argc_ff <= argc_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      bu_ff <= bu_in;
      au_ff <= au_in;
   end

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result written into a full queue");

   a_no_pop_pending : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !q_pop)
      else $error("item taken while a finish result is owed");

   a_pend_origin : assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> $past(out_push && out_res.kind == KIND_END))
      else $error("finish owed without an argument end before it");

   a_pend_drain : assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_full |=> !pend_ff)
      else $error("owed finish result not delivered");

endmodule

`default_nettype wire

// ----- bench/command_line_splitter_tb.sv -----
`timescale 1ns / 1ps

module command_line_splitter_tb;
   import cls_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 12;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic [7:0]  req_ch    = 8'h00;
   logic        rsp_pop   = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = CSR_COUNT_ONLY;
   logic [13:0] csr_data  = 14'd0;
   logic        req_full, rsp_empty, csr_ready;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [12:0] rsp_buf_offset;
   logic [11:0] rsp_arg_index;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_err_pos;
   logic [13:0] rsp_buf_used;
   logic [12:0] rsp_argv_used;
   logic        rsp_last;

   command_line_splitter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_ch         (req_ch),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_buf_offset (rsp_buf_offset),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_status     (rsp_status),
      .rsp_err_pos    (rsp_err_pos),
      .rsp_buf_used   (rsp_buf_used),
      .rsp_argv_used  (rsp_argv_used),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tokenizer shadow: register copy and per-command state
   cfg_type     regs_shadow = '{1'b0, BUF_CAP_RESET, ARGV_CAP_RESET};
   mode_type    scan        = MODE_BETWEEN;
   bit          dq_open     = 1'b0;
   bit          esc_armed   = 1'b0;
   logic [11:0] col         = '0;
   logic [13:0] buf_fill    = '0;
   logic [12:0] argc        = '0;
   logic [11:0] quote_col   = '0;

   result_type  tokens_due[$];
   logic [7:0]  cmd_chars[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          items_fed     = 0;
   int          mismatches    = 0;
   int          cycles        = 0;
   result_type  got, want;

   function automatic void restart_cmd();
      scan      = MODE_BETWEEN;
      dq_open   = 1'b0;
      esc_armed = 1'b0;
      col       = '0;
      buf_fill  = '0;
      argc      = '0;
      quote_col = '0;
   endfunction

   function automatic void note_token(rsp_kind_type k, logic [7:0] b, logic [12:0] off,
                                      logic [11:0] idx, status_type st, logic [11:0] ep,
                                      logic [13:0] bu, logic [12:0] au, logic lst);
      result_type r;
      r.kind       = k;
      r.out_byte   = b;
      r.buf_offset = off;
      r.arg_index  = idx;
      r.status     = st;
      r.err_pos    = ep;
      r.buf_used   = bu;
      r.argv_used  = au;
      r.last       = lst;
      tokens_due.push_back(r);
   endfunction

   function automatic void bump_col();
      if (col < 12'(CMD_LEN_DEFAULT - 1))
         col = col + 1'b1;
   endfunction

   function automatic bit buf_is_full();
      return !regs_shadow.count_only && buf_fill >= regs_shadow.buf_cap;
   endfunction

   // error finish; a terminator closes the command, anything else skips to it
   function automatic void abort_cmd(status_type st, logic [11:0] ep, logic [7:0] c);
      note_token(KIND_DONE, 8'h00, '0, '0, st, ep, '0, '0, 1'b1);
      if (c == CH_NUL)
         restart_cmd();
      else
         scan = MODE_SKIP;
   endfunction

   function automatic void finish_cmd();
      note_token(KIND_DONE, 8'h00, '0, '0, ST_OK, '0, buf_fill, argc + 1'b1, 1'b1);
      restart_cmd();
   endfunction

   function automatic void emit_arg(rsp_kind_type k, logic [7:0] b, logic [7:0] c);
      logic [12:0] idx;
      if (buf_is_full()) begin
         abort_cmd(ST_BUF_SMALL, '0, c);
         return;
      end
      idx = argc - 1'b1;
      note_token(k, b, buf_fill[12:0], idx[11:0], ST_OK, '0, '0, '0, 1'b0);
      if (buf_fill != DEST_MAX)
         buf_fill = buf_fill + 1'b1;
   endfunction

   function automatic void tokenize_char(logic [7:0] c);
      bit ws;
      ws = (c == CH_SPACE || c == CH_TAB || c == CH_LF);
      if (scan == MODE_SKIP) begin
         if (c == CH_NUL)
            restart_cmd();
         else
            bump_col();
         return;
      end
      if (col == 0 && scan == MODE_BETWEEN && !regs_shadow.count_only &&
          regs_shadow.argv_cap == 0) begin
         abort_cmd(ST_ARGV_SMALL, '0, c);
         return;
      end
      if (scan == MODE_BETWEEN) begin
         if (c == CH_NUL) begin
            finish_cmd();
            return;
         end
         if (ws) begin
            bump_col();
            return;
         end
         if (!regs_shadow.count_only &&
             int'(regs_shadow.argv_cap) < int'(argc) + 2) begin
            abort_cmd(ST_ARGV_SMALL, '0, c);
            return;
         end
         if (argc != ARGC_MAX)
            argc = argc + 1'b1;
         scan = MODE_ARG;
      end
      if (scan == MODE_STRONG) begin
         if (buf_is_full()) begin
            abort_cmd(ST_BUF_SMALL, '0, c);
            return;
         end
         if (c == CH_NUL) begin
            abort_cmd(ST_QUOTE, quote_col, c);
            return;
         end
         if (c == CH_SQ)
            scan = MODE_ARG;
         else
            emit_arg(KIND_BYTE, c, c);
         bump_col();
         return;
      end
      if (esc_armed) begin
         if (c == CH_NUL) begin
            abort_cmd(ST_ESCAPE, col - 1'b1, c);
            return;
         end
         esc_armed = 1'b0;
         emit_arg(KIND_BYTE, c, c);
      end else if (c == CH_DQ) begin
         dq_open   = !dq_open;
         quote_col = col;
      end else if (c == CH_BS) begin
         esc_armed = 1'b1;
      end else if (ws && !dq_open) begin
         emit_arg(KIND_END, 8'h00, c);
         if (scan != MODE_SKIP)
            scan = MODE_BETWEEN;
      end else if (c == CH_SQ && !dq_open) begin
         quote_col = col;
         if (buf_is_full()) begin
            abort_cmd(ST_BUF_SMALL, '0, c);
            return;
         end
         scan = MODE_STRONG;
      end else if (c == CH_NUL) begin
         if (dq_open) begin
            abort_cmd(ST_QUOTE, quote_col, c);
            return;
         end
         if (buf_is_full()) begin
            abort_cmd(ST_BUF_SMALL, '0, c);
            return;
         end
         emit_arg(KIND_END, 8'h00, c);
         finish_cmd();
         return;
      end else begin
         emit_arg(KIND_BYTE, c, c);
      end
      bump_col();
   endfunction

   function automatic string show_token(result_type r);
      return $sformatf("kind %0d byte %h off %0d arg %0d status %0d pos %0d used %0d/%0d last %0d",
                       r.kind, r.out_byte, r.buf_offset, r.arg_index, r.status, r.err_pos,
                       r.buf_used, r.argv_used, r.last);
   endfunction

   // result side: random pop, every accepted beat checked against the oldest token
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_kind, rsp_out_byte, rsp_buf_offset, rsp_arg_index, rsp_status,
                rsp_err_pos, rsp_buf_used, rsp_argv_used, rsp_last};
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %s", show_token(got));
         end else begin
            want = tokens_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch\n  expected %s\n  actual   %s",
                           show_token(want), show_token(got));
            end
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", tokens_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= c;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      if (scan != MODE_SKIP)
         items_fed++;
      tokenize_char(c);
   endtask

   task automatic send_text(input string s, input bit close = 1'b1);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
      if (close)
         send_char(CH_NUL);
   endtask

   // let every expected result drain, plus time for characters that give none
   task automatic wait_quiet();
      req_push <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [1:0] idx, input logic [13:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_COUNT_ONLY: regs_shadow.count_only = val[0];
         CSR_BUF_CAP:    regs_shadow.buf_cap    = val;
         CSR_ARGV_CAP:   regs_shadow.argv_cap   = val[12:0];
         default: ;
      endcase
   endtask

   task automatic load_regs(input bit co, input logic [13:0] bc, input logic [12:0] ac);
      wait_quiet();
      csr_beat(CSR_COUNT_ONLY, {13'd0, co});
      csr_beat(CSR_BUF_CAP, bc);
      csr_beat(CSR_ARGV_CAP, {1'b0, ac});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] pick;
      if ($urandom_range(9) < 7)
         return 8'h61 + 8'($urandom_range(25));
      do
         pick = 8'($urandom_range(1, 255));
      while (pick == CH_SPACE || pick == CH_TAB || pick == CH_LF || pick == CH_DQ ||
             pick == CH_SQ || pick == CH_BS);
      return pick;
   endfunction

   function automatic logic [7:0] ws_char();
      case ($urandom_range(2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         3:       return CH_DQ;
         4:       return CH_SQ;
         default: return CH_BS;
      endcase
   endfunction

   // mostly well-formed commands with random content, some noise and broken ones
   function automatic void build_command();
      int style, nargs, nseg, len;
      cmd_chars.delete();
      style = $urandom_range(9);
      if (style == 0) begin
         len = $urandom_range(14);
         for (int i = 0; i < len; i++)
            cmd_chars.push_back($urandom_range(1) ? 8'($urandom_range(1, 255))
                                                  : special_char());
      end else begin
         nargs = $urandom_range(5);
         if ($urandom_range(3) == 0)
            cmd_chars.push_back(ws_char());
         for (int a = 0; a < nargs; a++) begin
            nseg = $urandom_range(1, 3);
            for (int s = 0; s < nseg; s++) begin
               len = $urandom_range(5);
               case ($urandom_range(5))
                  0: begin
                     cmd_chars.push_back(CH_DQ);
                     for (int i = 0; i < len; i++)
                        case ($urandom_range(4))
                           0: cmd_chars.push_back(ws_char());
                           1: cmd_chars.push_back(CH_SQ);
                           2: begin
                              cmd_chars.push_back(CH_BS);
                              cmd_chars.push_back($urandom_range(1) ? CH_DQ : CH_BS);
                           end
                           default: cmd_chars.push_back(plain_char());
                        endcase
                     cmd_chars.push_back(CH_DQ);
                  end
                  1: begin
                     cmd_chars.push_back(CH_SQ);
                     for (int i = 0; i < len; i++)
                        case ($urandom_range(4))
                           0: cmd_chars.push_back(ws_char());
                           1: cmd_chars.push_back(CH_DQ);
                           2: cmd_chars.push_back(CH_BS);
                           default: cmd_chars.push_back(plain_char());
                        endcase
                     cmd_chars.push_back(CH_SQ);
                  end
                  2: begin
                     cmd_chars.push_back(CH_BS);
                     cmd_chars.push_back(8'($urandom_range(1, 255)));
                  end
                  default:
                     for (int i = 0; i <= len; i++)
                        cmd_chars.push_back(plain_char());
               endcase
            end
            len = $urandom_range(1, 2);
            for (int i = 0; i < len; i++)
               cmd_chars.push_back(ws_char());
         end
         if (style == 1)
            case ($urandom_range(2))
               0: cmd_chars.push_back(CH_BS);
               1: begin
                  cmd_chars.push_back(CH_DQ);
                  cmd_chars.push_back(plain_char());
               end
               default: begin
                  cmd_chars.push_back(CH_SQ);
                  cmd_chars.push_back(plain_char());
               end
            endcase
      end
      cmd_chars.push_back(CH_NUL);
   endfunction

   task automatic rand_regs();
      bit          co;
      logic [13:0] bc;
      logic [12:0] ac;
      co = ($urandom_range(3) == 0);
      case ($urandom_range(5))
         0:       bc = 14'd0;
         1:       bc = 14'($urandom_range(1, 24));
         2:       bc = 14'($urandom_range(25, 80));
         3:       bc = 14'($urandom_range(8192));
         default: bc = BUF_CAP_RESET;
      endcase
      case ($urandom_range(4))
         0:       ac = 13'd0;
         1:       ac = 13'($urandom_range(1, 6));
         2:       ac = 13'($urandom_range(4097));
         default: ac = ARGV_CAP_RESET;
      endcase
      load_regs(co, bc, ac);
   endtask

   task automatic test_plain_words();
      send_text(" \tab  c\nd ");
      send_char(8'h01);
      send_char(8'hff);
      send_char(8'h80);
      send_char(8'h7f);
      send_char(CH_NUL);
      send_text("");
      send_text(" \t\n");
   endtask

   task automatic test_quoting();
      send_text("\"a b\\\" 'c\" 'p \" q' e\\ f \"\" ''");
      send_text("x\\\\y\\'z\\\"");
   endtask

   task automatic test_errors();
      send_text("ab\\");
      send_text("a \"bc");
      send_text("a 'b\"c");
      send_text("a 'b' \"c d");
      load_regs(1'b0, 14'd3, ARGV_CAP_RESET);
      send_text("abcd ef");
      send_text("a'bcd'");
      load_regs(1'b0, 14'd2, ARGV_CAP_RESET);
      send_text("ab'c'");
      load_regs(1'b0, 14'd0, ARGV_CAP_RESET);
      send_text("");
      send_text(" a");
      load_regs(1'b0, BUF_CAP_RESET, 13'd2);
      send_text("a b c");
      load_regs(1'b0, BUF_CAP_RESET, 13'd0);
      send_text(" a");
      send_text("");
      load_regs(1'b1, 14'd0, 13'd0);
      send_text("ab 'c d' e");
   endtask

   // capacity shrinks while a command is open, with the pipeline drained
   task automatic test_regs_mid_command();
      load_regs(1'b0, BUF_CAP_RESET, ARGV_CAP_RESET);
      send_text("ab c", 1'b0);
      load_regs(1'b0, 14'd4, ARGV_CAP_RESET);
      send_text("de");
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int quota);
      int start;
      wait_quiet();
      send_idle_pct = tx_pct;
      recv_idle_pct = rx_pct;
      start = items_fed;
      while (items_fed - start < quota) begin
         if ($urandom_range(3) == 0)
            rand_regs();
         else if ($urandom_range(9) == 0)
            wait_quiet();
         build_command();
         foreach (cmd_chars[i])
            send_char(cmd_chars[i]);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 23;
      recv_idle_pct = 62;
      test_plain_words();
      test_quoting();
      test_errors();
      test_regs_mid_command();
      test_random(23, 62, 170);
      test_random(62, 23, 170);
      test_random(0, 0, 170);
      wait_quiet();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && tokens_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
